// File: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned TICKS_W = 10;
	localparam int unsigned POLL_W  = 8;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned BIT_W   = 4;

	localparam logic [TICKS_W-1:0] PHASE_TICKS_RST    = 10'd5;
	localparam logic [POLL_W-1:0]  ACK_POLL_LIMIT_RST = 8'd19;
	localparam logic [BIT_W-1:0]   BITS_PER_BYTE      = 4'd8;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT = 1'b1;

	// raw action codes on the input stream
	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	typedef enum logic [5:0] {
		KIND_TICK  = 6'b000001,
		KIND_START = 6'b000010,
		KIND_STOP  = 6'b000100,
		KIND_WRITE = 6'b001000,
		KIND_READ  = 6'b010000,
		KIND_NONE  = 6'b100000
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  tx_byte;
		logic               send_nack;
		logic               sda_in;
	} cmd_t;

	typedef enum logic [15:0] {
		PH_IDLE   = 16'h0001,
		PH_ST_A   = 16'h0002,
		PH_ST_B   = 16'h0004,
		PH_ST_C   = 16'h0008,
		PH_SP_A   = 16'h0010,
		PH_SP_B   = 16'h0020,
		PH_SP_C   = 16'h0040,
		PH_WR_LO  = 16'h0080,
		PH_WR_HI  = 16'h0100,
		PH_AK_SET = 16'h0200,
		PH_AK_POL = 16'h0400,
		PH_RD_PRE = 16'h0800,
		PH_RD_LO  = 16'h1000,
		PH_RD_HI  = 16'h2000,
		PH_NK_LO  = 16'h4000,
		PH_NK_HI  = 16'h8000
	} phase_t;

endpackage

// File: sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// unpacks input transactions and classifies the action code
// ----------------------------------------------------------------------------
module i2cm_front (
	input  logic [15:0]     s_tdata,  // action[2:0], tx_byte[10:3], send_nack[11], sda_in[12]
	output i2cm_pkg::cmd_t  cmd
);

	logic [2:0] action;

	assign action = s_tdata[2:0];

	always_comb begin
		cmd.tx_byte   = s_tdata[10:3];
		cmd.send_nack = s_tdata[11];
		cmd.sda_in    = s_tdata[12];
		case (action)
			i2cm_pkg::ACT_TICK:  cmd.kind = i2cm_pkg::KIND_TICK;
			i2cm_pkg::ACT_START: cmd.kind = i2cm_pkg::KIND_START;
			i2cm_pkg::ACT_STOP:  cmd.kind = i2cm_pkg::KIND_STOP;
			i2cm_pkg::ACT_WRITE: cmd.kind = i2cm_pkg::KIND_WRITE;
			i2cm_pkg::ACT_READ:  cmd.kind = i2cm_pkg::KIND_READ;
			default:             cmd.kind = i2cm_pkg::KIND_NONE;
		endcase
	end

endmodule

// File: sv/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// short command queue between the front and the bus sequencer
// ----------------------------------------------------------------------------
module i2cm_queue #(
	parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cm_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output i2cm_pkg::cmd_t  pop_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	i2cm_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// bus phase sequencer with configuration registers and output register
// ----------------------------------------------------------------------------
module i2cm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2cm_pkg::TICKS_W-1:0]      cfg_data,
	input  logic                              cmd_valid,
	input  i2cm_pkg::cmd_t                    cmd,
	output logic                              cmd_pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata  // scl_out[0], sda_out[1], busy_res[2], done_res[3], ack_seen[4], rx_byte[12:5]
);

	localparam int unsigned TW = i2cm_pkg::TICKS_W;
	localparam int unsigned PW = i2cm_pkg::POLL_W;
	localparam int unsigned BW = i2cm_pkg::BYTE_W;
	localparam int unsigned IW = i2cm_pkg::BIT_W;

	logic [TW-1:0]     phase_ticks_q;
	logic [PW-1:0]     ack_poll_limit_q;

	i2cm_pkg::phase_t  phase_q, phase_n;
	logic [IW-1:0]     bit_idx_q, bit_idx_n;
	logic [TW-1:0]     delay_q, delay_n;
	logic [PW-1:0]     poll_q, poll_n;
	logic [BW-1:0]     shift_q, shift_n;
	logic              scl_q, scl_n;
	logic              sda_q, sda_n;
	logic              ack_q, ack_n;
	logic              nack_q, nack_n;
	logic [BW-1:0]     rx_hold_q, rx_hold_n;
	logic              done_n;

	logic [TW-1:0]     eff_limit;
	logic [TW-1:0]     delay_inc;
	logic [IW-1:0]     bit_inc;
	logic [PW-1:0]     poll_inc;

	logic              out_valid_q;
	logic [12:0]       out_data_q;

	assign cmd_pop   = cmd_valid && (!out_valid_q || m_tready);
	assign eff_limit = (phase_ticks_q == '0) ? TW'(1) : phase_ticks_q;
	assign delay_inc = delay_q + 1'b1;
	assign bit_inc   = bit_idx_q + 1'b1;
	assign poll_inc  = poll_q + 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {3'b000, out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q    <= i2cm_pkg::PHASE_TICKS_RST;
			ack_poll_limit_q <= i2cm_pkg::ACK_POLL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cm_pkg::REG_PHASE_TICKS:    phase_ticks_q    <= cfg_data;
				i2cm_pkg::REG_ACK_POLL_LIMIT: ack_poll_limit_q <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_n   = phase_q;
		bit_idx_n = bit_idx_q;
		delay_n   = delay_q;
		poll_n    = poll_q;
		shift_n   = shift_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		ack_n     = ack_q;
		nack_n    = nack_q;
		rx_hold_n = rx_hold_q;
		done_n    = 1'b0;
		case (cmd.kind)
			i2cm_pkg::KIND_TICK: begin
				if (phase_q != i2cm_pkg::PH_IDLE) begin
					if (delay_inc >= eff_limit) begin
						delay_n = '0;
						case (phase_q)
							i2cm_pkg::PH_ST_A: begin
								sda_n = 1'b1;
								phase_n = i2cm_pkg::PH_ST_B;
							end
							i2cm_pkg::PH_ST_B: begin
								sda_n = 1'b0;
								phase_n = i2cm_pkg::PH_ST_C;
							end
							i2cm_pkg::PH_ST_C: begin
								scl_n = 1'b0;
								phase_n = i2cm_pkg::PH_IDLE;
								done_n = 1'b1;
							end
							i2cm_pkg::PH_SP_A: begin
								sda_n = 1'b0;
								phase_n = i2cm_pkg::PH_SP_B;
							end
							i2cm_pkg::PH_SP_B: begin
								scl_n = 1'b1;
								phase_n = i2cm_pkg::PH_SP_C;
							end
							i2cm_pkg::PH_SP_C: begin
								sda_n = 1'b1;
								phase_n = i2cm_pkg::PH_IDLE;
								done_n = 1'b1;
							end
							i2cm_pkg::PH_WR_LO: begin
								scl_n = 1'b1;
								phase_n = i2cm_pkg::PH_WR_HI;
							end
							i2cm_pkg::PH_WR_HI: begin
								scl_n = 1'b0;
								bit_idx_n = bit_inc;
								if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
									sda_n = 1'b1;
									phase_n = i2cm_pkg::PH_AK_SET;
								end else begin
									sda_n = shift_q[BW-1];
									shift_n = {shift_q[BW-2:0], 1'b0};
									phase_n = i2cm_pkg::PH_WR_LO;
								end
							end
							i2cm_pkg::PH_AK_SET: begin
								scl_n = 1'b1;
								poll_n = '0;
								if (ack_poll_limit_q == '0) begin
									ack_n = 1'b0;
									scl_n = 1'b0;
									sda_n = 1'b1;
									phase_n = i2cm_pkg::PH_IDLE;
									done_n = 1'b1;
								end else begin
									phase_n = i2cm_pkg::PH_AK_POL;
								end
							end
							i2cm_pkg::PH_AK_POL: begin
								poll_n = poll_inc;
								if (!cmd.sda_in || (poll_inc >= ack_poll_limit_q)) begin
									ack_n = !cmd.sda_in;
									scl_n = 1'b0;
									sda_n = 1'b1;
									phase_n = i2cm_pkg::PH_IDLE;
									done_n = 1'b1;
								end
							end
							i2cm_pkg::PH_RD_PRE: begin
								sda_n = 1'b1;
								phase_n = i2cm_pkg::PH_RD_LO;
							end
							i2cm_pkg::PH_RD_LO: begin
								scl_n = 1'b1;
								shift_n = {shift_q[BW-2:0], cmd.sda_in};
								phase_n = i2cm_pkg::PH_RD_HI;
							end
							i2cm_pkg::PH_RD_HI: begin
								scl_n = 1'b0;
								bit_idx_n = bit_inc;
								if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
									rx_hold_n = shift_q;
									sda_n = nack_q;
									phase_n = i2cm_pkg::PH_NK_LO;
								end else begin
									phase_n = i2cm_pkg::PH_RD_LO;
								end
							end
							i2cm_pkg::PH_NK_LO: begin
								scl_n = 1'b1;
								phase_n = i2cm_pkg::PH_NK_HI;
							end
							i2cm_pkg::PH_NK_HI: begin
								scl_n = 1'b0;
								phase_n = i2cm_pkg::PH_IDLE;
								done_n = 1'b1;
							end
							default: begin
								phase_n = i2cm_pkg::PH_IDLE;
							end
						endcase
					end else begin
						delay_n = delay_inc;
					end
				end
			end
			i2cm_pkg::KIND_START: begin
				if (phase_q == i2cm_pkg::PH_IDLE) begin
					delay_n = '0;
					bit_idx_n = '0;
					scl_n = 1'b1;
					phase_n = i2cm_pkg::PH_ST_A;
				end
			end
			i2cm_pkg::KIND_STOP: begin
				if (phase_q == i2cm_pkg::PH_IDLE) begin
					delay_n = '0;
					bit_idx_n = '0;
					scl_n = 1'b0;
					phase_n = i2cm_pkg::PH_SP_A;
				end
			end
			i2cm_pkg::KIND_WRITE: begin
				if (phase_q == i2cm_pkg::PH_IDLE) begin
					delay_n = '0;
					bit_idx_n = '0;
					scl_n = 1'b0;
					sda_n = cmd.tx_byte[BW-1];
					shift_n = {cmd.tx_byte[BW-2:0], 1'b0};
					phase_n = i2cm_pkg::PH_WR_LO;
				end
			end
			i2cm_pkg::KIND_READ: begin
				if (phase_q == i2cm_pkg::PH_IDLE) begin
					delay_n = '0;
					bit_idx_n = '0;
					shift_n = '0;
					nack_n = cmd.send_nack;
					phase_n = i2cm_pkg::PH_RD_PRE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cm_pkg::PH_IDLE;
			bit_idx_q   <= '0;
			delay_q     <= '0;
			poll_q      <= '0;
			shift_q     <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			nack_q      <= 1'b0;
			rx_hold_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				phase_q   <= phase_n;
				bit_idx_q <= bit_idx_n;
				delay_q   <= delay_n;
				poll_q    <= poll_n;
				shift_q   <= shift_n;
				scl_q     <= scl_n;
				sda_q     <= sda_n;
				ack_q     <= ack_n;
				nack_q    <= nack_n;
				rx_hold_q <= rx_hold_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_data_q <= {rx_hold_n, ack_n, done_n, (phase_n != i2cm_pkg::PH_IDLE), sda_n, scl_n};
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[3] |-> !out_data_q[2])
		else $error("done reported while still busy");

	a_bit_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_idx_q <= i2cm_pkg::BITS_PER_BYTE)
		else $error("bit index beyond one byte");

	a_idle_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cm_pkg::PH_IDLE |-> delay_q == '0)
		else $error("delay counter left running while idle");

	a_pop_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> out_valid_q)
		else $error("popped command produced no result");

endmodule

// File: sv/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master bit engine stepped by tick and command transactions
// ----------------------------------------------------------------------------
// usage:
// s_* carries one item per transaction: a tick with a sampled sda level, or
// a start, stop, write byte or read byte command. every accepted item gives
// exactly one result on m_*: scl and sda levels, busy, done, ack and rx byte.
// cfg_we writes phase_ticks (index 0) or ack_poll_limit (index 1); write
// only while no transaction is in flight.
// path: the queue is written at the accepting edge and the phase sequencer
// then loads its output register once that register is empty or being taken;
// the result is held there until m_tready takes it.
// throughput: one item per cycle while m_tready is high; the phase sequencer
// updates all of its state for each item it takes.
// reset: bus levels released high, sequencer idle, queue and output empty,
// registers back to 5 ticks per phase and 19 ack polls.
// stall: while m_tready is low the result holds, the sequencer stops and the
// queue absorbs up to QUEUE_DEPTH items before s_tready drops.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
	parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i2cm_pkg::TICKS_W-1:0]    cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,  // action[2:0], tx_byte[10:3], send_nack[11], sda_in[12]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata   // scl_out[0], sda_out[1], busy_res[2], done_res[3], ack_seen[4], rx_byte[12:5]
);

	i2cm_pkg::cmd_t front_cmd;
	i2cm_pkg::cmd_t queue_cmd;
	logic           queue_full;
	logic           queue_valid;
	logic           queue_pop;

	assign s_tready = !queue_full;

	i2cm_front u_front (
		.s_tdata (s_tdata),
		.cmd     (front_cmd)
	);

	i2cm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_cmd  (front_cmd),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_valid),
		.pop_cmd   (queue_cmd)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.cmd_pop   (queue_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
